// ----- src/kra_pkg.sv -----
// Shared types and constants of the keystroke rate arousal tracker.
// Used by the divider and the top level.
package kra_pkg;

    localparam int TIME_BITS = 48;

    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [DIV_W-1:0] RATE_NUM     = 64'd65536000000;
    localparam logic [DIV_W-1:0] MIN_GAP_US   = 64'd50000;
    localparam logic [DIV_W-1:0] VAR_FLOOR    = 64'd65536000000;
    localparam logic [DIV_W-1:0] VAR_SEED_ADD = 64'd65536000;
    localparam logic [DIV_W-1:0] T_LIMIT      = 64'd1048576;
    localparam logic [31:0]      ONE31        = 32'h8000_0000;
    localparam logic [31:0]      AR_MAGIC     = 32'd2199023256;
    localparam logic [3:0]       HORNER_TERMS = 4'd12;

    typedef enum logic [2:0] {
        CFG_RATE_SMOOTHING    = 3'd0,
        CFG_STATS_SMOOTHING   = 3'd1,
        CFG_AROUSAL_THRESHOLD = 3'd2,
        CFG_AROUSAL_CAP       = 3'd3,
        CFG_STREAK_SCALE      = 3'd4,
        CFG_BASE_ALPHA        = 3'd5,
        CFG_MIN_ALPHA         = 3'd6,
        CFG_UNUSED            = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

endpackage

// ----- src/kra_div.sv -----
// Restoring divider, one quotient bit per cycle, 64 steps per division.
// Depends on kra_pkg.
module kra_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kra_pkg::div_req_t        req,
    output logic [kra_pkg::DIV_W-1:0] quo,
    output logic                     done
);
    import kra_pkg::*;

    logic [DIV_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   num_reg, num_next;
    logic [DIV_W-1:0]   den_reg;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_W:0]     trial;
    logic               ge;

    always_comb begin
        trial    = {rem_reg[DIV_W-1:0], num_reg[DIV_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? trial - {1'b0, den_reg} : trial;
        quo_next = {quo_reg[DIV_W-2:0], ge};
        num_next = {num_reg[DIV_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            busy_reg <= cnt_reg != DIV_CNT_W'(DIV_W - 1);
            done_reg <= cnt_reg == DIV_CNT_W'(DIV_W - 1);
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            num_reg <= req.num;
            den_reg <= req.den;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ----- src/kra_mul.sv -----
// Shared 32x32 multiplier with a registered product.
// No dependencies.
module kra_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- src/keystroke_rate_arousal_tracker_core.sv -----
// Keystroke rate arousal tracker: sequencer around a shared divider and multiplier.
// A word runs up to 14 divisions through the 64-step divider, fewer with no gap or when
// the decay is skipped.
// The next word is taken once the result is parked, and a stalled result holds the input.
// Reset (aresetn, synchronous, active low) clears history, streak and loads register defaults.
// Depends on kra_pkg, kra_div, kra_mul.
module keystroke_rate_arousal_tracker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [kra_pkg::TIME_BITS-1:0]  s_key_time_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_arousal_level,
    output logic signed [1:0]              m_deviation_sign,
    output logic [31:0]                    m_deviation_size,
    output logic [15:0]                    m_streak_count,
    output logic [15:0]                    m_effective_alpha,
    output logic                           m_stats_ready,
    input  logic                           cfg_wen,
    input  logic [2:0]                     cfg_index,
    input  logic [31:0]                    cfg_wdata
);
    import kra_pkg::*;

    typedef enum logic [23:0] {
        ST_IDLE       = 24'd1 << 0,
        ST_DWAIT      = 24'd1 << 1,
        ST_MWAIT      = 24'd1 << 2,
        ST_RATE_DONE  = 24'd1 << 3,
        ST_RATE_EMA   = 24'd1 << 4,
        ST_STATS      = 24'd1 << 5,
        ST_SEED       = 24'd1 << 6,
        ST_VAR_D      = 24'd1 << 7,
        ST_MEAN_EMA   = 24'd1 << 8,
        ST_VAR_EMA    = 24'd1 << 9,
        ST_AROUSAL    = 24'd1 << 10,
        ST_AR_DONE    = 24'd1 << 11,
        ST_STREAK     = 24'd1 << 12,
        ST_ALPHA      = 24'd1 << 13,
        ST_T_DONE     = 24'd1 << 14,
        ST_HORN       = 24'd1 << 15,
        ST_HORN_DIV   = 24'd1 << 16,
        ST_HORN_SUB   = 24'd1 << 17,
        ST_SQ         = 24'd1 << 18,
        ST_SQ_DONE    = 24'd1 << 19,
        ST_FINAL      = 24'd1 << 20,
        ST_ALPHA_DONE = 24'd1 << 21,
        ST_OUT        = 24'd1 << 22,
        ST_AR_Q       = 24'd1 << 23
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [15:0] rsm_reg, ssm_reg, l0_reg, balpha_reg, malpha_reg;
    logic [31:0] thr_reg, cap_reg;

    logic [TIME_BITS-1:0] last_reg, last_next;
    logic        have_last_reg, have_last_next;
    logic [31:0] rate_reg, rate_next;
    logic        have_rate_reg, have_rate_next;
    logic [31:0] mean_reg, mean_next;
    logic [31:0] var_reg, var_next;
    logic        have_stats_reg, have_stats_next;
    logic [15:0] streak_reg, streak_next;

    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [31:0] tmp_reg, tmp_next;
    logic        dir_reg, dir_next;
    logic [30:0] u_reg, u_next;
    logic [31:0] r_reg, r_next;
    logic [3:0]  k_reg, k_next;
    logic [1:0]  sq_reg, sq_next;
    logic        upd_reg, upd_next;
    logic [31:0] ar_reg, ar_next;
    logic [15:0] eff_reg, eff_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] o_ar_reg, o_size_reg;
    logic [1:0]  o_sign_reg;
    logic [15:0] o_streak_reg, o_eff_reg;
    logic        o_ready_reg;

    div_req_t         div_req;
    logic [DIV_W-1:0] div_quo;
    logic             div_done;
    logic [63:0]      mul_p;

    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] gap;
    logic [DIV_W-1:0]     gap_w;
    logic [31:0]          dev;
    logic                 rate_ge;
    logic [63:0]          seed_sum;
    logic [31:0]          d2;
    logic [31:0]          step;
    logic                 load_out;
    logic [25:0]          ar_q;
    logic [31:0]          ar_q125;
    logic [6:0]           ar_rem;
    logic [31:0]          ar_sum;

    kra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .quo     (div_quo),
        .done    (div_done)
    );

    kra_mul u_mul (
        .aclk (aclk),
        .a    (ma_reg),
        .b    (mb_reg),
        .p    (mul_p)
    );

    assign s_ready  = state_reg == ST_IDLE;
    assign now      = s_key_time_us;
    assign gap      = now - last_reg;
    assign gap_w    = 64'(gap);
    assign rate_ge  = rate_reg >= mean_reg;
    assign dev      = rate_ge ? rate_reg - mean_reg : mean_reg - rate_reg;
    assign seed_sum = (mul_p >> 18) + VAR_SEED_ADD;
    assign d2       = |mul_p[63:48] ? 32'hFFFF_FFFF : mul_p[47:16];
    assign step     = mul_p[47:16];
    assign load_out = state_reg == ST_OUT && (!m_valid_reg || m_ready);

    // variance never reaches the floor, so sigma is fixed: arousal = dev * 32 / 125
    assign ar_q    = mul_p[63:38];
    assign ar_q125 = 32'({ar_q, 7'd0}) - 32'({ar_q, 1'b0}) - 32'(ar_q);
    assign ar_rem  = 7'(dev - ar_q125);
    assign ar_sum  = tmp_reg + {6'd0, ar_q};

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        last_next       = last_reg;
        have_last_next  = have_last_reg;
        rate_next       = rate_reg;
        have_rate_next  = have_rate_reg;
        mean_next       = mean_reg;
        var_next        = var_reg;
        have_stats_next = have_stats_reg;
        streak_next     = streak_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        tmp_next        = tmp_reg;
        dir_next        = dir_reg;
        u_next          = u_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        sq_next         = sq_reg;
        upd_next        = upd_reg;
        ar_next         = ar_reg;
        eff_next        = eff_reg;
        div_req.start   = 1'b0;
        div_req.num     = '0;
        div_req.den     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next      = now;
                    have_last_next = 1'b1;
                    upd_next       = have_last_reg && now > last_reg;
                    if (have_last_reg && now > last_reg) begin
                        div_req.start = 1'b1;
                        div_req.num   = RATE_NUM;
                        div_req.den   = gap_w < MIN_GAP_US ? MIN_GAP_US : gap_w;
                        ret_next      = ST_RATE_DONE;
                        state_next    = ST_DWAIT;
                    end else begin
                        state_next = ST_AROUSAL;
                    end
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    state_next = ret_reg;
                end
            end
            ST_MWAIT: begin
                state_next = ret_reg;
            end
            ST_RATE_DONE: begin
                if (have_rate_reg) begin
                    tmp_next   = div_quo[31:0];
                    dir_next   = div_quo[31:0] >= rate_reg;
                    ma_next    = 32'(rsm_reg);
                    mb_next    = div_quo[31:0] >= rate_reg ? div_quo[31:0] - rate_reg
                                                           : rate_reg - div_quo[31:0];
                    ret_next   = ST_RATE_EMA;
                    state_next = ST_MWAIT;
                end else begin
                    rate_next      = div_quo[31:0];
                    have_rate_next = 1'b1;
                    state_next     = ST_STATS;
                end
            end
            ST_RATE_EMA: begin
                rate_next  = dir_reg ? rate_reg + step : rate_reg - step;
                state_next = ST_STATS;
            end
            ST_STATS: begin
                if (!have_stats_reg) begin
                    ma_next  = rate_reg;
                    mb_next  = rate_reg;
                    ret_next = ST_SEED;
                end else begin
                    ma_next  = dev;
                    mb_next  = dev;
                    ret_next = ST_VAR_D;
                end
                state_next = ST_MWAIT;
            end
            ST_SEED: begin
                mean_next       = rate_reg;
                var_next        = |seed_sum[63:32] ? 32'hFFFF_FFFF : seed_sum[31:0];
                have_stats_next = 1'b1;
                state_next      = ST_AROUSAL;
            end
            ST_VAR_D: begin
                tmp_next   = d2;
                dir_next   = rate_ge;
                ma_next    = 32'(ssm_reg);
                mb_next    = dev;
                ret_next   = ST_MEAN_EMA;
                state_next = ST_MWAIT;
            end
            ST_MEAN_EMA: begin
                mean_next  = dir_reg ? mean_reg + step : mean_reg - step;
                dir_next   = tmp_reg >= var_reg;
                ma_next    = 32'(ssm_reg);
                mb_next    = tmp_reg >= var_reg ? tmp_reg - var_reg : var_reg - tmp_reg;
                ret_next   = ST_VAR_EMA;
                state_next = ST_MWAIT;
            end
            ST_VAR_EMA: begin
                var_next   = dir_reg ? var_reg + step : var_reg - step;
                state_next = ST_AROUSAL;
            end
            ST_AROUSAL: begin
                if (have_rate_reg && have_stats_reg) begin
                    ma_next    = dev;
                    mb_next    = AR_MAGIC;
                    ret_next   = ST_AR_Q;
                    state_next = ST_MWAIT;
                end else begin
                    ar_next    = '0;
                    state_next = ST_STREAK;
                end
            end
            ST_AR_Q: begin
                tmp_next   = {1'b0, ar_q, 5'd0};
                ma_next    = {20'd0, ar_rem, 5'd0};
                mb_next    = AR_MAGIC;
                ret_next   = ST_AR_DONE;
                state_next = ST_MWAIT;
            end
            ST_AR_DONE: begin
                ar_next    = ar_sum > cap_reg ? cap_reg : ar_sum;
                state_next = ST_STREAK;
            end
            ST_STREAK: begin
                if (upd_reg) begin
                    if (ar_reg > thr_reg) begin
                        streak_next = streak_reg == 16'hFFFF ? streak_reg : streak_reg + 1'b1;
                    end else begin
                        streak_next = '0;
                    end
                end
                state_next = ST_ALPHA;
            end
            ST_ALPHA: begin
                div_req.start = 1'b1;
                div_req.num   = 64'(streak_reg) << 16;
                div_req.den   = l0_reg == '0 ? 64'd1 : 64'(l0_reg);
                ret_next      = ST_T_DONE;
                state_next    = ST_DWAIT;
            end
            ST_T_DONE: begin
                if (div_quo >= T_LIMIT) begin
                    r_next     = '0;
                    state_next = ST_FINAL;
                end else begin
                    u_next     = {div_quo[19:0], 11'd0};
                    r_next     = ONE31;
                    k_next     = HORNER_TERMS;
                    state_next = ST_HORN;
                end
            end
            ST_HORN: begin
                ma_next    = 32'(u_reg);
                mb_next    = r_reg;
                ret_next   = ST_HORN_DIV;
                state_next = ST_MWAIT;
            end
            ST_HORN_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = mul_p >> 31;
                div_req.den   = 64'(k_reg);
                ret_next      = ST_HORN_SUB;
                state_next    = ST_DWAIT;
            end
            ST_HORN_SUB: begin
                r_next = ONE31 - div_quo[31:0];
                if (k_reg == 4'd1) begin
                    sq_next    = '0;
                    state_next = ST_SQ;
                end else begin
                    k_next     = k_reg - 1'b1;
                    state_next = ST_HORN;
                end
            end
            ST_SQ: begin
                ma_next    = r_reg;
                mb_next    = r_reg;
                ret_next   = ST_SQ_DONE;
                state_next = ST_MWAIT;
            end
            ST_SQ_DONE: begin
                r_next  = mul_p[62:31];
                sq_next = sq_reg + 1'b1;
                state_next = sq_reg == 2'd3 ? ST_FINAL : ST_SQ;
            end
            ST_FINAL: begin
                ma_next    = 32'(balpha_reg);
                mb_next    = r_reg;
                ret_next   = ST_ALPHA_DONE;
                state_next = ST_MWAIT;
            end
            ST_ALPHA_DONE: begin
                eff_next   = mul_p[46:31] < malpha_reg ? malpha_reg : mul_p[46:31];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            have_last_reg  <= 1'b0;
            have_rate_reg  <= 1'b0;
            have_stats_reg <= 1'b0;
            streak_reg     <= '0;
            m_valid_reg    <= 1'b0;
            rsm_reg        <= 16'd13107;
            ssm_reg        <= 16'd3277;
            thr_reg        <= 32'd16777216;
            cap_reg        <= 32'd50331648;
            l0_reg         <= 16'd10;
            balpha_reg     <= 16'd19661;
            malpha_reg     <= 16'd3277;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            have_last_reg  <= have_last_next;
            have_rate_reg  <= have_rate_next;
            have_stats_reg <= have_stats_next;
            streak_reg     <= streak_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wen) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_RATE_SMOOTHING:    rsm_reg    <= cfg_wdata[15:0];
                    CFG_STATS_SMOOTHING:   ssm_reg    <= cfg_wdata[15:0];
                    CFG_AROUSAL_THRESHOLD: thr_reg    <= cfg_wdata;
                    CFG_AROUSAL_CAP:       cap_reg    <= cfg_wdata;
                    CFG_STREAK_SCALE:      l0_reg     <= cfg_wdata[15:0];
                    CFG_BASE_ALPHA:        balpha_reg <= cfg_wdata[15:0];
                    CFG_MIN_ALPHA:         malpha_reg <= cfg_wdata[15:0];
                    CFG_UNUSED: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        rate_reg <= rate_next;
        mean_reg <= mean_next;
        var_reg  <= var_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        tmp_reg  <= tmp_next;
        dir_reg  <= dir_next;
        u_reg    <= u_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        sq_reg   <= sq_next;
        upd_reg  <= upd_next;
        ar_reg   <= ar_next;
        eff_reg  <= eff_next;
        if (load_out) begin
            o_ready_reg  <= have_rate_reg && have_stats_reg;
            o_ar_reg     <= ar_reg;
            o_sign_reg   <= !(have_rate_reg && have_stats_reg) ? 2'b00 :
                            rate_ge ? 2'b01 : 2'b11;
            o_size_reg   <= (have_rate_reg && have_stats_reg) ? dev : 32'd0;
            o_streak_reg <= streak_reg;
            o_eff_reg    <= eff_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_arousal_level   = o_ar_reg;
    assign m_deviation_sign  = o_sign_reg;
    assign m_deviation_size  = o_size_reg;
    assign m_streak_count    = o_streak_reg;
    assign m_effective_alpha = o_eff_reg;
    assign m_stats_ready     = o_ready_reg;

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in flight");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_no_stats_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_stats_ready |-> m_arousal_level == 32'd0 && m_deviation_size == 32'd0)
        else $error("deviation reported without statistics");

endmodule
